// ===== hdl/eyegb_pkg.sv =====
package eyegb_pkg;

    // fixed field widths
    localparam int CfgIdxW = 3;
    localparam int CfgDataW = 12;

    // full scale and dead bands, Q8.8 percent
    localparam int FullPct = 25600;
    localparam int GazeDead = 102;
    localparam int LidDead = 128;
    localparam int MsPerSec = 1000;

    localparam int MaxStepMsDef = 200;

    // register reset values
    localparam logic [7:0] GazeEaseRst = 8'd18;
    localparam logic [11:0] GazeRateRst = 12'd600;
    localparam logic [11:0] LidRateRst = 12'd250;
    localparam logic [9:0] CloseMsRst = 10'd80;
    localparam logic [9:0] HoldMsRst = 10'd70;
    localparam logic [9:0] OpenMsRst = 10'd150;
    localparam logic [7:0] LidTrackRst = 8'd0;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_GAZE_EASE = 3'd0,
        CFG_GAZE_RATE = 3'd1,
        CFG_LID_RATE  = 3'd2,
        CFG_CLOSE_MS  = 3'd3,
        CFG_HOLD_MS   = 3'd4,
        CFG_OPEN_MS   = 3'd5,
        CFG_LID_TRACK = 3'd6
    } cfg_idx_t;

    // blink phase codes
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_CLOSE = 2'd1;
    localparam logic [1:0] PH_SHUT = 2'd2;
    localparam logic [1:0] PH_OPEN = 2'd3;

endpackage

// ===== hdl/eye_gaze_blink_profiler_top.sv =====
// channel | direction | handshake             | word
// --------+-----------+-----------------------+-------------------------------------------
// in      | input     | in_valid / in_ready   | elapsed_ms, targets, lid_base, requests
// out     | output    | out_valid / out_ready | gaze_x, gaze_y, lid_pos, phase, moved flags
// cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data (always ready)
//
// one word at a time; a tick runs seven steps through one bit-serial shift-add
// multiplier and one restoring divider (one quotient bit a cycle); a rest request
// skips the steps and goes straight to the done state
// reset clears gaze, lid, phase, phase time and loads register defaults
// a finished word sits in the output register; the next input word is taken
// while it waits, and a second result waits in the done state until out_ready
module eye_gaze_blink_profiler_top #(
    parameter int MAX_STEP_MS = eyegb_pkg::MaxStepMsDef
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [15:0]                     elapsed_ms,
    input  logic signed [15:0]              target_x,
    input  logic signed [15:0]              target_y,
    input  logic [14:0]                     lid_base,
    input  logic                            blink_request,
    input  logic                            rest_request,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic signed [15:0]              gaze_x,
    output logic signed [15:0]              gaze_y,
    output logic [14:0]                     lid_pos,
    output logic [1:0]                      blink_phase,
    output logic                            gaze_moved,
    output logic                            lid_moved,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [eyegb_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [eyegb_pkg::CfgDataW-1:0]  cfg_data
);
    import eyegb_pkg::*;

    // dt width, multiplier operand and product widths follow the step limit
    localparam int DT_W = $clog2(MAX_STEP_MS + 1);
    localparam int ED_W = 8 + DT_W;
    localparam int MUL_N = (ED_W > 16) ? ED_W : 16;
    localparam int PROD_W = (24 + DT_W > 31) ? 24 + DT_W : 31;
    localparam int CNT_W = $clog2(PROD_W + 1);
    localparam logic [DT_W-1:0] DT_MAX = DT_W'(MAX_STEP_MS);
    localparam logic [15:0] DT_LIM = 16'(MAX_STEP_MS);
    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(MUL_N - 1);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(PROD_W - 1);
    localparam logic signed [15:0] G_MAX = 16'(FullPct);
    localparam logic signed [15:0] G_MIN = -G_MAX;
    localparam logic signed [16:0] G_DEAD = 17'(GazeDead);
    localparam logic signed [16:0] L_DEAD = 17'(LidDead);
    localparam logic [14:0] L_FULL = 15'(FullPct);
    localparam logic [9:0] MS_DIV = 10'(MsPerSec);

    typedef enum logic [2:0] {
        S_IDLE, S_LOAD, S_MUL, S_MID, S_DIV, S_POST, S_DONE
    } state_t;

    // one pass through the shared multiplier per step, and through the divider for all steps but ST_ED and ST_TRK
    typedef enum logic [2:0] {
        ST_CAPG, ST_ED, ST_GX, ST_GY, ST_TRK, ST_INTERP, ST_CAPL
    } step_t;

    // configuration registers
    logic [7:0]  ease_reg;
    logic [11:0] grate_reg;
    logic [11:0] lrate_reg;
    logic [9:0]  close_reg;
    logic [9:0]  hold_reg;
    logic [9:0]  open_reg;
    logic [7:0]  track_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ease_reg  <= GazeEaseRst;
            grate_reg <= GazeRateRst;
            lrate_reg <= LidRateRst;
            close_reg <= CloseMsRst;
            hold_reg  <= HoldMsRst;
            open_reg  <= OpenMsRst;
            track_reg <= LidTrackRst;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_GAZE_EASE: ease_reg  <= cfg_data[7:0];
                CFG_GAZE_RATE: grate_reg <= cfg_data;
                CFG_LID_RATE:  lrate_reg <= cfg_data;
                CFG_CLOSE_MS:  close_reg <= cfg_data[9:0];
                CFG_HOLD_MS:   hold_reg  <= cfg_data[9:0];
                CFG_OPEN_MS:   open_reg  <= cfg_data[9:0];
                CFG_LID_TRACK: track_reg <= cfg_data[7:0];
                default:       ;
            endcase
        end
    end

    state_t state_reg, state_next;
    step_t  step_reg, step_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    // tick state
    logic signed [15:0] gx_reg, gx_next;
    logic signed [15:0] gy_reg, gy_next;
    logic [14:0] lid_reg, lid_next;
    logic [1:0]  phase_reg, phase_next;
    logic [15:0] pt_reg, pt_next;

    // per-tick working values
    logic [DT_W-1:0] dt_reg, dt_next;
    logic signed [16:0] ex_reg, ex_next;
    logic signed [16:0] ey_reg, ey_next;
    logic [14:0] base_reg, base_next;
    logic gmove_reg, gmove_next;
    logic lmove_reg, lmove_next;
    logic [PROD_W-1:0] capg_reg, capg_next;
    logic [ED_W-1:0] ed_reg, ed_next;
    logic [14:0] t_reg, t_next;
    logic [14:0] iq_reg, iq_next;

    // serial multiplier and divider
    logic [PROD_W-1:0] ma_reg, ma_next;
    logic [MUL_N-1:0] mb_reg, mb_next;
    logic [PROD_W-1:0] acc_reg, acc_next;
    logic [PROD_W-1:0] dq_reg, dq_next;
    logic [9:0] rem_reg, rem_next;
    logic [9:0] dv_reg, dv_next;

    // output register
    logic ov_reg, ov_next;
    logic signed [15:0] ogx_reg, ogx_next;
    logic signed [15:0] ogy_reg, ogy_next;
    logic [14:0] olid_reg, olid_next;
    logic [1:0] oph_reg, oph_next;
    logic ogm_reg, ogm_next;
    logic olm_reg, olm_next;

    // temporaries
    logic signed [15:0] txc, tyc;
    logic signed [16:0] exw, eyw;
    logic [16:0] ptsum;
    logic [16:0] emag;
    logic [9:0] len;
    logic [10:0] rsh;
    logic [15:0] trk;
    logic signed [17:0] tsum;
    logic signed [16:0] le;
    logic [15:0] lmag, lstep;

    function automatic logic signed [15:0] gaze_apply(
        input logic signed [15:0] cur,
        input logic neg,
        input logic [PROD_W-1:0] q,
        input logic [PROD_W-1:0] cap
    );
        logic [PROD_W-1:0] s;
        logic signed [PROD_W+1:0] ext, st, sum;
        logic signed [PROD_W+1:0] hi, lo;
        s = (q > cap) ? cap : q;
        ext = {{(PROD_W-14){cur[15]}}, cur};
        st = {2'b00, s};
        sum = neg ? ext - st : ext + st;
        hi = (PROD_W+2)'(G_MAX);
        lo = -hi;
        if (sum > hi)
            return G_MAX;
        else if (sum < lo)
            return G_MIN;
        else
            return sum[15:0];
    endfunction

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        step_next = step_reg;
        cnt_next = cnt_reg;
        gx_next = gx_reg;
        gy_next = gy_reg;
        lid_next = lid_reg;
        phase_next = phase_reg;
        pt_next = pt_reg;
        dt_next = dt_reg;
        ex_next = ex_reg;
        ey_next = ey_reg;
        base_next = base_reg;
        gmove_next = gmove_reg;
        lmove_next = lmove_reg;
        capg_next = capg_reg;
        ed_next = ed_reg;
        t_next = t_reg;
        iq_next = iq_reg;
        ma_next = ma_reg;
        mb_next = mb_reg;
        acc_next = acc_reg;
        dq_next = dq_reg;
        rem_next = rem_reg;
        dv_next = dv_reg;
        ov_next = ov_reg;
        ogx_next = ogx_reg;
        ogy_next = ogy_reg;
        olid_next = olid_reg;
        oph_next = oph_reg;
        ogm_next = ogm_reg;
        olm_next = olm_reg;

        txc = (target_x > G_MAX) ? G_MAX : ((target_x < G_MIN) ? G_MIN : target_x);
        tyc = (target_y > G_MAX) ? G_MAX : ((target_y < G_MIN) ? G_MIN : target_y);
        exw = {txc[15], txc} - {gx_reg[15], gx_reg};
        eyw = {tyc[15], tyc} - {gy_reg[15], gy_reg};
        ptsum = {1'b0, pt_reg} + {1'b0, elapsed_ms};
        emag = 17'd0;
        len = (phase_reg == PH_OPEN) ? open_reg : close_reg;
        if (len == 10'd0)
            len = 10'd1;
        rsh = {rem_reg, dq_reg[PROD_W-1]};
        trk = acc_reg[23:8];
        tsum = gy_reg[15] ? {3'b000, base_reg} + {2'b00, trk}
                          : {3'b000, base_reg} - {2'b00, trk};
        le = {2'b00, t_reg} - {2'b00, lid_reg};
        lmag = le[16] ? 16'(-le) : le[15:0];
        lstep = (dq_reg < PROD_W'(lmag)) ? dq_reg[15:0] : lmag;

        if (ov_reg && out_ready)
            ov_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (rest_request)
                    begin
                        gx_next = '0;
                        gy_next = '0;
                        lid_next = '0;
                        phase_next = PH_IDLE;
                        pt_next = '0;
                        gmove_next = 1'b1;
                        lmove_next = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        dt_next = (elapsed_ms > DT_LIM) ? DT_MAX : elapsed_ms[DT_W-1:0];
                        ex_next = exw;
                        ey_next = eyw;
                        gmove_next = (exw > G_DEAD) || (exw < -G_DEAD) ||
                                     (eyw > G_DEAD) || (eyw < -G_DEAD);
                        lmove_next = 1'b0;
                        base_next = (lid_base > L_FULL) ? L_FULL : lid_base;
                        if (blink_request)
                        begin
                            phase_next = PH_CLOSE;
                            pt_next = '0;
                        end
                        else
                            pt_next = ptsum[16] ? 16'hFFFF : ptsum[15:0];
                        step_next = ST_CAPG;
                        state_next = S_LOAD;
                    end
                end
            end

            S_LOAD:
            begin
                acc_next = '0;
                cnt_next = '0;
                state_next = S_MUL;
                case (step_reg)
                    ST_CAPG:
                    begin
                        ma_next = PROD_W'(grate_reg);
                        mb_next = MUL_N'(dt_reg);
                    end
                    ST_ED:
                    begin
                        ma_next = PROD_W'(ease_reg);
                        mb_next = MUL_N'(dt_reg);
                    end
                    ST_GX:
                    begin
                        emag = ex_reg[16] ? 17'(-ex_reg) : ex_reg;
                        ma_next = PROD_W'(emag[15:0]);
                        mb_next = MUL_N'(ed_reg);
                    end
                    ST_GY:
                    begin
                        emag = ey_reg[16] ? 17'(-ey_reg) : ey_reg;
                        ma_next = PROD_W'(emag[15:0]);
                        mb_next = MUL_N'(ed_reg);
                    end
                    ST_TRK:
                    begin
                        emag = gy_reg[15] ? 17'(-{gy_reg[15], gy_reg}) : {1'b0, gy_reg};
                        ma_next = PROD_W'(emag[15:0]);
                        mb_next = MUL_N'(track_reg);
                    end
                    ST_INTERP:
                    begin
                        ma_next = PROD_W'(L_FULL - t_reg);
                        mb_next = MUL_N'(pt_reg);
                    end
                    default:
                    begin
                        ma_next = PROD_W'(lrate_reg);
                        mb_next = MUL_N'(dt_reg);
                    end
                endcase
            end

            S_MUL:
            begin
                if (mb_reg[0])
                    acc_next = acc_reg + ma_reg;
                ma_next = {ma_reg[PROD_W-2:0], 1'b0};
                mb_next = {1'b0, mb_reg[MUL_N-1:1]};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == MUL_LAST)
                    state_next = S_MID;
            end

            S_MID:
            begin
                rem_next = '0;
                cnt_next = '0;
                state_next = S_DIV;
                case (step_reg)
                    ST_CAPG, ST_CAPL:
                    begin
                        // rate * 256 * dt / 1000
                        dq_next = {acc_reg[PROD_W-9:0], 8'd0};
                        dv_next = MS_DIV;
                    end
                    ST_GX, ST_GY:
                    begin
                        dq_next = acc_reg;
                        dv_next = MS_DIV;
                    end
                    ST_INTERP:
                    begin
                        dq_next = acc_reg;
                        dv_next = len;
                    end
                    default:
                        state_next = S_POST;
                endcase
            end

            S_DIV:
            begin
                if (rsh >= {1'b0, dv_reg})
                begin
                    rem_next = 10'(rsh - {1'b0, dv_reg});
                    dq_next = {dq_reg[PROD_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rsh[9:0];
                    dq_next = {dq_reg[PROD_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST)
                    state_next = S_POST;
            end

            S_POST:
            begin
                state_next = S_LOAD;
                case (step_reg)
                    ST_CAPG:
                    begin
                        capg_next = dq_reg;
                        step_next = ST_ED;
                    end
                    ST_ED:
                    begin
                        ed_next = acc_reg[ED_W-1:0];
                        step_next = ST_GX;
                    end
                    ST_GX:
                    begin
                        if (gmove_reg)
                            gx_next = gaze_apply(gx_reg, ex_reg[16], dq_reg, capg_reg);
                        step_next = ST_GY;
                    end
                    ST_GY:
                    begin
                        if (gmove_reg)
                            gy_next = gaze_apply(gy_reg, ey_reg[16], dq_reg, capg_reg);
                        step_next = ST_TRK;
                    end
                    ST_TRK:
                    begin
                        // lid target: base minus y * track / 256, clamped
                        if (tsum < 18'sd0)
                            t_next = '0;
                        else if (tsum > 18'(FullPct))
                            t_next = L_FULL;
                        else
                            t_next = tsum[14:0];
                        step_next = ST_INTERP;
                    end
                    ST_INTERP:
                    begin
                        iq_next = dq_reg[14:0];
                        step_next = ST_CAPL;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                        case (phase_reg)
                            PH_CLOSE:
                            begin
                                lmove_next = 1'b1;
                                if (pt_reg >= {6'd0, len})
                                begin
                                    lid_next = L_FULL;
                                    phase_next = PH_SHUT;
                                    pt_next = '0;
                                end
                                else
                                    lid_next = t_reg + iq_reg;
                            end
                            PH_SHUT:
                            begin
                                lmove_next = 1'b1;
                                lid_next = L_FULL;
                                if (pt_reg >= {6'd0, hold_reg})
                                begin
                                    phase_next = PH_OPEN;
                                    pt_next = '0;
                                end
                            end
                            PH_OPEN:
                            begin
                                lmove_next = 1'b1;
                                if (pt_reg >= {6'd0, len})
                                begin
                                    phase_next = PH_IDLE;
                                    pt_next = '0;
                                    lid_next = t_reg;
                                end
                                else
                                    lid_next = L_FULL - iq_reg;
                            end
                            default:
                            begin
                                // idle slew, the divider holds the lid cap
                                if ((le > L_DEAD) || (le < -L_DEAD))
                                begin
                                    lmove_next = 1'b1;
                                    lid_next = le[16] ? lid_reg - lstep[14:0]
                                                      : lid_reg + lstep[14:0];
                                end
                            end
                        endcase
                    end
                endcase
            end

            S_DONE:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next = 1'b1;
                    ogx_next = gx_reg;
                    ogy_next = gy_reg;
                    olid_next = lid_reg;
                    oph_next = phase_reg;
                    ogm_next = gmove_reg;
                    olm_next = lmove_reg;
                    state_next = S_IDLE;
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg <= ST_CAPG;
            cnt_reg <= '0;
            gx_reg <= '0;
            gy_reg <= '0;
            lid_reg <= '0;
            phase_reg <= PH_IDLE;
            pt_reg <= '0;
            gmove_reg <= 1'b0;
            lmove_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg <= step_next;
            cnt_reg <= cnt_next;
            gx_reg <= gx_next;
            gy_reg <= gy_next;
            lid_reg <= lid_next;
            phase_reg <= phase_next;
            pt_reg <= pt_next;
            gmove_reg <= gmove_next;
            lmove_reg <= lmove_next;
            ov_reg <= ov_next;
        end
    end

    // datapath, no reset needed
    always_ff @(posedge clk)
    begin
        dt_reg <= dt_next;
        ex_reg <= ex_next;
        ey_reg <= ey_next;
        base_reg <= base_next;
        capg_reg <= capg_next;
        ed_reg <= ed_next;
        t_reg <= t_next;
        iq_reg <= iq_next;
        ma_reg <= ma_next;
        mb_reg <= mb_next;
        acc_reg <= acc_next;
        dq_reg <= dq_next;
        rem_reg <= rem_next;
        dv_reg <= dv_next;
        ogx_reg <= ogx_next;
        ogy_reg <= ogy_next;
        olid_reg <= olid_next;
        oph_reg <= oph_next;
        ogm_reg <= ogm_next;
        olm_reg <= olm_next;
    end

    assign out_valid = ov_reg;
    assign gaze_x = ogx_reg;
    assign gaze_y = ogy_reg;
    assign lid_pos = olid_reg;
    assign blink_phase = oph_reg;
    assign gaze_moved = ogm_reg;
    assign lid_moved = olm_reg;

endmodule

// ===== hdl/eyegb_checker.sv =====
module eyegb_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_ready,
    input logic signed [15:0]  gaze_x,
    input logic signed [15:0]  gaze_y,
    input logic [14:0]         lid_pos,
    input logic [1:0]          blink_phase,
    input logic                lid_moved
);
    import eyegb_pkg::*;

    // a pending word is held until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("out word dropped while stalled");

    a_lid_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> lid_pos <= 15'(FullPct))
        else $error("lid out of range");

    a_gaze_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (gaze_x <= 16'(FullPct)) && (gaze_x >= -16'(FullPct)) &&
                      (gaze_y <= 16'(FullPct)) && (gaze_y >= -16'(FullPct)))
        else $error("gaze out of range");

    // shut phase reports full closure
    a_shut_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (blink_phase == PH_SHUT) |-> lid_pos == 15'(FullPct))
        else $error("shut phase with lid not closed");

    // a running blink always writes the lid
    a_blink_moves: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (blink_phase != PH_IDLE) |-> lid_moved)
        else $error("blink phase without lid write");

endmodule

bind eye_gaze_blink_profiler_top eyegb_checker u_eyegb_checker (.*);

// ===== tb/testbench.sv =====
module testbench;
    import eyegb_pkg::*;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic [15:0] elapsed_ms;
    logic signed [15:0] target_x;
    logic signed [15:0] target_y;
    logic [14:0] lid_base;
    logic blink_request;
    logic rest_request;
    logic out_valid;
    logic out_ready;
    logic signed [15:0] gaze_x;
    logic signed [15:0] gaze_y;
    logic [14:0] lid_pos;
    logic [1:0] blink_phase;
    logic gaze_moved;
    logic lid_moved;
    logic cfg_valid;
    logic cfg_ready;
    logic [CfgIdxW-1:0] cfg_index;
    logic [CfgDataW-1:0] cfg_data;

    // one tick word and one result word
    typedef struct packed {
        logic [15:0] elapsed;
        logic signed [15:0] tx;
        logic signed [15:0] ty;
        logic [14:0] base;
        logic blink;
        logic rest;
    } tick_t;

    typedef struct packed {
        logic signed [15:0] gx;
        logic signed [15:0] gy;
        logic [14:0] lid;
        logic [1:0] ph;
        logic gmv;
        logic lmv;
    } pose_t;

    // directed row: tick plus an optional typed-in result
    typedef struct packed {
        tick_t tick;
        logic has_pose;
        pose_t pose;
    } row_t;

    localparam int LatencyCycles = 400;

    eye_gaze_blink_profiler_top i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .elapsed_ms(elapsed_ms), .target_x(target_x), .target_y(target_y),
        .lid_base(lid_base), .blink_request(blink_request), .rest_request(rest_request),
        .out_valid(out_valid), .out_ready(out_ready),
        .gaze_x(gaze_x), .gaze_y(gaze_y), .lid_pos(lid_pos), .blink_phase(blink_phase),
        .gaze_moved(gaze_moved), .lid_moved(lid_moved),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // predictor copy of registers and state
    longint m_ease, m_grate, m_lrate, m_close, m_hold, m_open, m_track;
    longint m_gx, m_gy, m_lid, m_ptime;
    logic [1:0] m_ph;

    pose_t expected_poses[$];
    int errors;
    bit stim_done;
    bit long_hold;

    function automatic longint clampl(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic void reset_model();
        m_ease = GazeEaseRst; m_grate = GazeRateRst; m_lrate = LidRateRst;
        m_close = CloseMsRst; m_hold = HoldMsRst; m_open = OpenMsRst;
        m_track = LidTrackRst;
        m_gx = 0; m_gy = 0; m_lid = 0; m_ptime = 0; m_ph = PH_IDLE;
    endfunction

    function automatic void config_model(cfg_idx_t idx, logic [CfgDataW-1:0] val);
        case (idx)
            CFG_GAZE_EASE: m_ease = val[7:0];
            CFG_GAZE_RATE: m_grate = val;
            CFG_LID_RATE:  m_lrate = val;
            CFG_CLOSE_MS:  m_close = val[9:0];
            CFG_HOLD_MS:   m_hold = val[9:0];
            CFG_OPEN_MS:   m_open = val[9:0];
            CFG_LID_TRACK: m_track = val[7:0];
            default: ;
        endcase
    endfunction

    // one tick of the eye: rest request, gaze easing, blink profile, idle lid slew
    function automatic pose_t advance_eye(tick_t t);
        pose_t p;
        longint tx, ty, base, dt, ex, ey, cap, sx, sy, tgt, len, e;
        tx = clampl(longint'(t.tx), -FullPct, FullPct);
        ty = clampl(longint'(t.ty), -FullPct, FullPct);
        base = clampl(longint'(t.base), 0, FullPct);
        p.gmv = 0;
        p.lmv = 0;
        if (t.rest) begin
            m_gx = 0; m_gy = 0; m_lid = 0; m_ph = PH_IDLE; m_ptime = 0;
            p.gmv = 1; p.lmv = 1;
        end
        else begin
            dt = t.elapsed > MaxStepMsDef ? MaxStepMsDef : t.elapsed;
            if (t.blink) begin
                m_ph = PH_CLOSE;
                m_ptime = 0;
            end
            else begin
                m_ptime = m_ptime + t.elapsed;
                if (m_ptime > 65535) m_ptime = 65535;
            end
            ex = tx - m_gx;
            ey = ty - m_gy;
            if (ex > GazeDead || ex < -GazeDead || ey > GazeDead || ey < -GazeDead) begin
                cap = (m_grate * 256 * dt) / MsPerSec;
                sx = clampl((ex * m_ease * dt) / MsPerSec, -cap, cap);
                sy = clampl((ey * m_ease * dt) / MsPerSec, -cap, cap);
                m_gx = clampl(m_gx + sx, -FullPct, FullPct);
                m_gy = clampl(m_gy + sy, -FullPct, FullPct);
                p.gmv = 1;
            end
            tgt = clampl(base - (m_gy * m_track) / 256, 0, FullPct);
            case (m_ph)
                PH_CLOSE:
                begin
                    len = m_close ? m_close : 1;
                    if (m_ptime >= len) begin
                        m_lid = FullPct; m_ph = PH_SHUT; m_ptime = 0;
                    end
                    else m_lid = tgt + ((FullPct - tgt) * m_ptime) / len;
                    p.lmv = 1;
                end
                PH_SHUT:
                begin
                    m_lid = FullPct;
                    if (m_ptime >= m_hold) begin
                        m_ph = PH_OPEN; m_ptime = 0;
                    end
                    p.lmv = 1;
                end
                PH_OPEN:
                begin
                    len = m_open ? m_open : 1;
                    if (m_ptime >= len) begin
                        m_ph = PH_IDLE; m_ptime = 0; m_lid = tgt;
                    end
                    else m_lid = FullPct - ((FullPct - tgt) * m_ptime) / len;
                    p.lmv = 1;
                end
                default:
                begin
                    e = tgt - m_lid;
                    if (e > LidDead || e < -LidDead) begin
                        cap = (m_lrate * 256 * dt) / MsPerSec;
                        m_lid = clampl(m_lid + clampl(e, -cap, cap), 0, FullPct);
                        p.lmv = 1;
                    end
                end
            endcase
        end
        p.gx = m_gx[15:0];
        p.gy = m_gy[15:0];
        p.lid = m_lid[14:0];
        p.ph = m_ph;
        return p;
    endfunction

    // clock
    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #20000000;
        $display("FAILURE");
        $finish;
    end

    function automatic int rand_gap();
        if ($urandom_range(0, 9) == 0) return $urandom_range(0, 40);
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 3);
    endfunction

    // one register write, after which the channel is left idle
    task automatic write_reg(cfg_idx_t idx, logic [CfgDataW-1:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 0;
        config_model(idx, val);
        @(posedge clk);
    endtask

    // wait until all results are in plus a latency margin
    task automatic drain();
        while (expected_poses.size() != 0) @(posedge clk);
        repeat (LatencyCycles) @(posedge clk);
    endtask

    task automatic send_tick(tick_t t);
        int gap;
        gap = rand_gap();
        if (gap > 0) begin
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1;
        elapsed_ms <= t.elapsed;
        target_x <= t.tx;
        target_y <= t.ty;
        lid_base <= t.base;
        blink_request <= t.blink;
        rest_request <= t.rest;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        expected_poses.push_back(advance_eye(t));
    endtask

    function automatic tick_t mk(int el, int tx, int ty, int b, bit bl, bit rs);
        tick_t t;
        t.elapsed = 16'(el); t.tx = 16'(tx); t.ty = 16'(ty); t.base = 15'(b);
        t.blink = bl; t.rest = rs;
        return t;
    endfunction

    function automatic pose_t mkp(int gx, int gy, int lid, logic [1:0] ph, bit g, bit l);
        pose_t p;
        p.gx = 16'(gx); p.gy = 16'(gy); p.lid = 15'(lid); p.ph = ph; p.gmv = g; p.lmv = l;
        return p;
    endfunction

    // random tick: mostly in range, sometimes out-of-range encodings
    function automatic tick_t rand_tick();
        tick_t t;
        int r;
        r = $urandom_range(0, 19);
        t.elapsed = 16'((r == 0) ? $urandom : $urandom_range(0, 260));
        t.tx = 16'((r == 1) ? $urandom : $urandom_range(0, 51200) - 25600);
        t.ty = 16'((r == 2) ? $urandom : $urandom_range(0, 51200) - 25600);
        t.base = 15'((r == 3) ? $urandom : $urandom_range(0, 25600));
        t.blink = ($urandom_range(0, 11) == 0);
        t.rest = ($urandom_range(0, 39) == 0);
        return t;
    endfunction

    // directed table
    row_t dir_rows[$];

    task automatic build_table();
        row_t r;
        r.has_pose = 0;
        r.pose = '0;
        // after reset, zero elapsed, targets at rest: nothing moves
        r.tick = mk(0, 0, 0, 0, 0, 0); r.has_pose = 1;
        r.pose = mkp(0, 0, 0, PH_IDLE, 0, 0); dir_rows.push_back(r);
        // rest request forces everything to zero
        r.tick = mk(100, 25600, -25600, 25600, 1, 1);
        r.pose = mkp(0, 0, 0, PH_IDLE, 1, 1); dir_rows.push_back(r);
        // inside the gaze dead band
        r.tick = mk(50, 102, -102, 0, 0, 0);
        r.pose = mkp(0, 0, 0, PH_IDLE, 0, 0); dir_rows.push_back(r);
        r.has_pose = 0;
        r.tick = mk(65535, 25600, 25600, 25600, 0, 0); dir_rows.push_back(r);
        r.tick = mk(200, -32768, 32767, 32767, 0, 0); dir_rows.push_back(r);
        r.tick = mk(300, 32767, -32768, 0, 0, 0); dir_rows.push_back(r);
        r.tick = mk(10, 103, 0, 129, 0, 0); dir_rows.push_back(r);
        // blink: request, closing, restart, shut, open, back to idle
        r.tick = mk(40, 0, 0, 5000, 1, 0); dir_rows.push_back(r);
        r.tick = mk(40, 0, 0, 5000, 0, 0); dir_rows.push_back(r);
        r.tick = mk(30, 0, 0, 5000, 1, 0); dir_rows.push_back(r);
        r.tick = mk(100, 0, 0, 5000, 0, 0); dir_rows.push_back(r);
        r.tick = mk(70, 0, 0, 5000, 0, 0); dir_rows.push_back(r);
        r.tick = mk(60, 0, 0, 5000, 0, 0); dir_rows.push_back(r);
        r.tick = mk(100, 0, 0, 5000, 0, 0); dir_rows.push_back(r);
        r.tick = mk(65535, 0, 0, 5000, 0, 0); dir_rows.push_back(r);
        r.tick = mk(65535, 0, 0, 5000, 0, 0); dir_rows.push_back(r);
        r.tick = mk(1, 0, -25600, 0, 0, 0); dir_rows.push_back(r);
        r.tick = mk(200, 0, -25600, 0, 0, 0); dir_rows.push_back(r);
        r.tick = mk(0, 0, 0, 0, 1, 0); dir_rows.push_back(r);
        r.tick = mk(0, 0, 0, 0, 0, 1); dir_rows.push_back(r);
    endtask

    // sender
    initial
    begin
        int n;
        tick_t t;
        rst_n = 0;
        in_valid = 0;
        elapsed_ms = 0; target_x = 0; target_y = 0; lid_base = 0;
        blink_request = 0; rest_request = 0;
        cfg_valid = 0; cfg_index = CFG_GAZE_EASE; cfg_data = 0;
        errors = 0;
        stim_done = 0;
        long_hold = 0;
        reset_model();
        build_table();
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed part at reset settings
        foreach (dir_rows[i]) begin
            send_tick(dir_rows[i].tick);
            if (dir_rows[i].has_pose) expected_poses[$] = dir_rows[i].pose;
        end
        in_valid <= 0;
        drain();

        // zero phase lengths, max tracking, extreme rates
        write_reg(CFG_CLOSE_MS, 0);
        write_reg(CFG_OPEN_MS, 0);
        write_reg(CFG_HOLD_MS, 0);
        write_reg(CFG_LID_TRACK, 255);
        write_reg(CFG_GAZE_EASE, 255);
        write_reg(CFG_GAZE_RATE, 4095);
        write_reg(CFG_LID_RATE, 4095);
        for (n = 0; n < 12; n++) send_tick(rand_tick());
        send_tick(mk(0, 0, 25600, 0, 1, 0));
        send_tick(mk(1, 0, 25600, 0, 0, 0));
        send_tick(mk(1, 0, 25600, 0, 0, 0));
        in_valid <= 0;
        drain();

        // random phases, all but the first with fresh settings; long receiver hold in one
        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 5) begin
                write_reg(CFG_GAZE_EASE, 0);
                write_reg(CFG_GAZE_RATE, 0);
                write_reg(CFG_LID_RATE, 0);
                write_reg(CFG_CLOSE_MS, 1023);
                write_reg(CFG_HOLD_MS, 1023);
                write_reg(CFG_OPEN_MS, 1023);
                write_reg(CFG_LID_TRACK, 0);
            end
            else if (ph > 0) begin
                write_reg(CFG_GAZE_EASE, 12'($urandom_range(0, 255)));
                write_reg(CFG_GAZE_RATE, 12'($urandom_range(0, 4095)));
                write_reg(CFG_LID_RATE, 12'($urandom_range(0, 4095)));
                write_reg(CFG_CLOSE_MS, 12'($urandom_range(0, 300)));
                write_reg(CFG_HOLD_MS, 12'($urandom_range(0, 300)));
                write_reg(CFG_OPEN_MS, 12'($urandom_range(0, 300)));
                write_reg(CFG_LID_TRACK, 12'($urandom_range(0, 255)));
            end
            if (ph == 2) long_hold = 1;
            for (n = 0; n < 85; n++) begin
                t = rand_tick();
                send_tick(t);
            end
            in_valid <= 0;
            // sender pauses until every result is in
            drain();
        end
        stim_done = 1;
    end

    // receiver: random stalls, one long hold-off
    initial
    begin
        int gap;
        out_ready = 0;
        @(posedge rst_n);
        forever begin
            if (long_hold) begin
                long_hold = 0;
                out_ready <= 0;
                repeat (3000) @(posedge clk);
            end
            gap = rand_gap();
            if (gap > 0) begin
                out_ready <= 0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1;
            @(posedge clk);
        end
    end

    // checker: compare each accepted result to the oldest expectation
    always @(posedge clk)
    begin
        pose_t exp_p;
        if (rst_n && out_valid && out_ready) begin
            if (expected_poses.size() == 0) begin
                $error("result word with no expectation waiting");
                errors++;
            end
            else begin
                exp_p = expected_poses.pop_front();
                if (gaze_x !== exp_p.gx) begin
                    $error("gaze_x expected %0d actual %0d", exp_p.gx, gaze_x); errors++;
                end
                if (gaze_y !== exp_p.gy) begin
                    $error("gaze_y expected %0d actual %0d", exp_p.gy, gaze_y); errors++;
                end
                if (lid_pos !== exp_p.lid) begin
                    $error("lid_pos expected %0d actual %0d", exp_p.lid, lid_pos); errors++;
                end
                if (blink_phase !== exp_p.ph) begin
                    $error("blink_phase expected %0d actual %0d", exp_p.ph, blink_phase);
                    errors++;
                end
                if (gaze_moved !== exp_p.gmv) begin
                    $error("gaze_moved expected %0d actual %0d", exp_p.gmv, gaze_moved);
                    errors++;
                end
                if (lid_moved !== exp_p.lmv) begin
                    $error("lid_moved expected %0d actual %0d", exp_p.lmv, lid_moved);
                    errors++;
                end
            end
        end
    end

    // end of run
    initial
    begin
        wait (stim_done);
        @(posedge clk);
        if (expected_poses.size() != 0) begin
            $error("expectations left over: %0d", expected_poses.size());
            errors++;
        end
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
